// ----- hdl/uss_pkg.sv -----
// ----------------------------------------------------------------------------
// uss_pkg
// Types, codes and helpers shared by the update session supervisor.
// ----------------------------------------------------------------------------
package uss_pkg;

	typedef enum logic [1:0] {
		CMD_START       = 2'd0,
		CMD_STATUS      = 2'd1,
		CMD_TICK        = 2'd2,
		CMD_STREAM_DONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RS_IDLE      = 2'd0,
		RS_RECEIVING = 2'd1,
		RS_READY     = 2'd2,
		RS_FAILED    = 2'd3
	} rstate_t;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_WAIT_BEGIN = 2'd1,
		PH_STREAMING  = 2'd2,
		PH_WAIT_END   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_STARTED   = 3'd1,
		EV_REFUSED   = 3'd2,
		EV_POLL      = 3'd3,
		EV_STREAMING = 3'd4,
		EV_DONE      = 3'd5,
		EV_FAILED    = 3'd6
	} event_t;

	typedef enum logic [3:0] {
		FR_NONE             = 4'd0,
		FR_LINK_LOST        = 4'd1,
		FR_BEGIN_REJECTED   = 4'd2,
		FR_PEER_FAILED      = 4'd3,
		FR_BEGIN_TIMEOUT    = 4'd4,
		FR_FINALIZE_FAILED  = 4'd5,
		FR_FINALIZE_TIMEOUT = 4'd6,
		FR_BUSY             = 4'd7,
		FR_BAD_CHUNK        = 4'd8,
		FR_BAD_FILE         = 4'd9,
		FR_NO_TARGET        = 4'd10
	} reason_t;

	typedef enum logic [1:0] {
		CFG_BEGIN_TIMEOUT = 2'd0,
		CFG_END_TIMEOUT   = 2'd1,
		CFG_POLL_INTERVAL = 2'd2
	} cfg_idx_t;

	localparam logic [30:0] BEGIN_TIMEOUT_RST = 31'd12000;
	localparam logic [30:0] END_TIMEOUT_RST   = 31'd60000;
	localparam logic [30:0] POLL_INTERVAL_RST = 31'd250;
	localparam logic [15:0] CHUNK_MIN         = 16'd32;
	localparam logic [15:0] CHUNK_MAX         = 16'd220;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] now_ms;
		logic [15:0] chunk_size;
		logic [31:0] file_size;
		logic        file_ok;
		logic        target_ok;
		logic        link_ok;
		logic        code_ok;
		rstate_t     remote_state;
		logic [31:0] rx_bytes;
		logic [31:0] total_bytes;
	} item_t;

	typedef struct packed {
		event_t      event_res;
		reason_t     fail_reason;
		logic [31:0] duration_ms;
		logic        session_active;
		phase_t      session_phase;
	} result_t;

	typedef struct packed {
		cfg_idx_t    idx;
		logic [31:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [30:0] begin_timeout_ms;
		logic [30:0] end_timeout_ms;
		logic [30:0] poll_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic        active;
		phase_t      phase;
		logic [31:0] image_size;
		logic [7:0]  chunk_len;
		logic [31:0] start_time;
		logic [31:0] last_activity;
		logic [31:0] last_poll;
		logic        begin_seen;
	} sess_t;

	function automatic logic reached(logic [31:0] now, logic [31:0] then_ms,
			logic [30:0] limit);
		logic [31:0] d;
		d = now - then_ms;
		return !d[31] && (d[30:0] >= limit);
	endfunction

endpackage

// ----- hdl/uss_chan_if.sv -----
// ----------------------------------------------------------------------------
// uss_chan_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface uss_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/uss_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// uss_cfg_regs
// Timeout and poll interval registers behind the configuration channel.
// ----------------------------------------------------------------------------
module uss_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	uss_chan_if.sink      cfg,
	output uss_pkg::cfg_t regs
);
	uss_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.begin_timeout_ms <= uss_pkg::BEGIN_TIMEOUT_RST;
			regs_q.end_timeout_ms   <= uss_pkg::END_TIMEOUT_RST;
			regs_q.poll_interval_ms <= uss_pkg::POLL_INTERVAL_RST;
		end else if (cfg.valid) begin
			case (cfg.data.idx)
				uss_pkg::CFG_BEGIN_TIMEOUT: regs_q.begin_timeout_ms <= cfg.data.value[30:0];
				uss_pkg::CFG_END_TIMEOUT:   regs_q.end_timeout_ms   <= cfg.data.value[30:0];
				uss_pkg::CFG_POLL_INTERVAL: regs_q.poll_interval_ms <= cfg.data.value[30:0];
				default: ;
			endcase
		end
	end
endmodule

// ----- hdl/uss_step.sv -----
// ----------------------------------------------------------------------------
// uss_step
// Next session state and result for one request.
// ----------------------------------------------------------------------------
module uss_step (
	input  uss_pkg::item_t   item,
	input  uss_pkg::sess_t   cur,
	input  uss_pkg::cfg_t    regs,
	output uss_pkg::sess_t   nxt,
	output uss_pkg::result_t res
);
	logic             do_end;
	uss_pkg::event_t  end_ev;
	uss_pkg::reason_t end_why;
	uss_pkg::reason_t why;
	uss_pkg::sess_t   upd;
	uss_pkg::event_t  ev;
	uss_pkg::reason_t ev_why;

	always_comb begin
		upd     = cur;
		ev      = uss_pkg::EV_NONE;
		ev_why  = uss_pkg::FR_NONE;
		do_end  = 1'b0;
		end_ev  = uss_pkg::EV_FAILED;
		end_why = uss_pkg::FR_NONE;
		why     = uss_pkg::FR_NONE;

		case (item.cmd)
			uss_pkg::CMD_START: begin
				if (!item.target_ok)
					why = uss_pkg::FR_NO_TARGET;
				else if (cur.active)
					why = uss_pkg::FR_BUSY;
				else if (item.chunk_size < uss_pkg::CHUNK_MIN ||
						item.chunk_size > uss_pkg::CHUNK_MAX)
					why = uss_pkg::FR_BAD_CHUNK;
				else if (!item.file_ok || item.file_size == 32'd0)
					why = uss_pkg::FR_BAD_FILE;
				if (why != uss_pkg::FR_NONE) begin
					ev     = uss_pkg::EV_REFUSED;
					ev_why = why;
				end else begin
					upd.active        = 1'b1;
					upd.phase         = uss_pkg::PH_WAIT_BEGIN;
					upd.image_size    = item.file_size;
					upd.chunk_len     = item.chunk_size[7:0];
					upd.start_time    = item.now_ms;
					upd.last_activity = item.now_ms;
					upd.last_poll     = 32'd0;
					upd.begin_seen    = 1'b0;
					ev                = uss_pkg::EV_STARTED;
				end
			end
			uss_pkg::CMD_STATUS: begin
				if (cur.active) begin
					upd.last_activity = item.now_ms;
					if (cur.phase == uss_pkg::PH_WAIT_BEGIN) begin
						if (!item.code_ok) begin
							do_end  = 1'b1;
							end_why = uss_pkg::FR_BEGIN_REJECTED;
						end else if (item.remote_state == uss_pkg::RS_FAILED) begin
							do_end  = 1'b1;
							end_why = uss_pkg::FR_PEER_FAILED;
						end else if (item.remote_state == uss_pkg::RS_RECEIVING) begin
							upd.begin_seen = 1'b1;
							upd.phase      = uss_pkg::PH_STREAMING;
							ev             = uss_pkg::EV_STREAMING;
						end
					end else if (cur.phase == uss_pkg::PH_WAIT_END) begin
						if (!item.code_ok || item.remote_state == uss_pkg::RS_FAILED) begin
							do_end  = 1'b1;
							end_why = uss_pkg::FR_FINALIZE_FAILED;
						end else if (item.remote_state == uss_pkg::RS_READY &&
								item.rx_bytes == cur.image_size &&
								item.total_bytes == cur.image_size) begin
							do_end = 1'b1;
							end_ev = uss_pkg::EV_DONE;
						end
					end
				end
			end
			uss_pkg::CMD_TICK: begin
				if (cur.active) begin
					if (!item.link_ok) begin
						do_end  = 1'b1;
						end_why = uss_pkg::FR_LINK_LOST;
					end else if (cur.phase == uss_pkg::PH_WAIT_BEGIN) begin
						if (uss_pkg::reached(item.now_ms, cur.last_activity,
								regs.begin_timeout_ms)) begin
							do_end  = 1'b1;
							end_why = uss_pkg::FR_BEGIN_TIMEOUT;
						end else if (cur.begin_seen) begin
							upd.phase = uss_pkg::PH_STREAMING;
							ev        = uss_pkg::EV_STREAMING;
						end else if (uss_pkg::reached(item.now_ms, cur.last_poll,
								regs.poll_interval_ms)) begin
							upd.last_poll = item.now_ms;
							ev            = uss_pkg::EV_POLL;
						end
					end else if (cur.phase == uss_pkg::PH_WAIT_END) begin
						if (uss_pkg::reached(item.now_ms, cur.last_activity,
								regs.end_timeout_ms)) begin
							do_end  = 1'b1;
							end_why = uss_pkg::FR_FINALIZE_TIMEOUT;
						end
					end
				end
			end
			uss_pkg::CMD_STREAM_DONE: begin
				if (cur.active && cur.phase == uss_pkg::PH_STREAMING) begin
					upd.phase         = uss_pkg::PH_WAIT_END;
					upd.last_activity = item.now_ms;
				end
			end
			default: ;
		endcase

		nxt            = upd;
		res.event_res  = ev;
		res.fail_reason = ev_why;
		res.duration_ms = 32'd0;
		if (do_end) begin
			nxt.active        = 1'b0;
			nxt.phase         = uss_pkg::PH_IDLE;
			nxt.image_size    = 32'd0;
			nxt.start_time    = 32'd0;
			nxt.last_activity = 32'd0;
			nxt.last_poll     = 32'd0;
			nxt.begin_seen    = 1'b0;
			res.event_res     = end_ev;
			res.fail_reason   = end_why;
			res.duration_ms   = item.now_ms - cur.start_time;
		end
		res.session_active = nxt.active;
		res.session_phase  = nxt.phase;
	end
endmodule

// ----- hdl/update_session_supervisor_top.sv -----
// ----------------------------------------------------------------------------
// update_session_supervisor_top
// Firmware-push session supervisor: start checks, status replies, polls
// and timeouts, one result per request.
//
//   channel  modport  payload              use
//   req      sink     uss_pkg::item_t      start, status, tick, stream done
//   res      source   uss_pkg::result_t    event, reason, elapsed, phase
//   cfg      sink     uss_pkg::cfg_wr_t    register index and write data
//
// One request per cycle sustained while res is ready; a taken request passes
// through the input register, then the result register.
// Session state updates in the same cycle the result register loads.
// Reset returns the registers to their defaults and the session to idle.
// A stalled result holds the result register; the input register takes at
// most one more request and then holds until the result moves on.
// cfg is always ready.
// ----------------------------------------------------------------------------
module update_session_supervisor_top (
	input  logic       clk,
	input  logic       arst_n,
	uss_chan_if.sink   req,
	uss_chan_if.source res,
	uss_chan_if.sink   cfg
);
	uss_pkg::cfg_t    regs;
	uss_pkg::item_t   item_s1;
	logic             valid_s1;
	uss_pkg::sess_t   sess_q;
	uss_pkg::sess_t   sess_nxt;
	uss_pkg::result_t step_res;
	uss_pkg::result_t res_s2;
	logic             valid_s2;
	logic             adv;

	uss_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	uss_step u_step (
		.item (item_s1),
		.cur  (sess_q),
		.regs (regs),
		.nxt  (sess_nxt),
		.res  (step_res)
	);

	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || adv;
	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				sess_q <= sess_nxt;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= step_res;
		end
	end

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!sess_q.active |-> sess_q.phase == uss_pkg::PH_IDLE)
		else $error("idle session with nonidle phase");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.event_res == uss_pkg::EV_DONE ||
			res_s2.event_res == uss_pkg::EV_FAILED)
		|-> !res_s2.session_active && res_s2.session_phase == uss_pkg::PH_IDLE)
		else $error("session end left session open");

	a_reason_only_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.fail_reason != uss_pkg::FR_NONE
		|-> res_s2.event_res == uss_pkg::EV_REFUSED ||
			res_s2.event_res == uss_pkg::EV_FAILED)
		else $error("fail reason without failure event");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_s2.session_active == sess_q.active &&
			res_s2.session_phase == sess_q.phase)
		else $error("reported phase differs from session state");

	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced request produced no result");
endmodule
